// File: src/wbnr_pkg.sv
`default_nettype none
package wbnr_pkg;

  typedef enum logic [1:0] {
    MODE_REF   = 2'd0,
    MODE_BAND  = 2'd1,
    MODE_PROBE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 9;
  localparam logic [CfgIdxW-1:0] CFG_REF_COUNT  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BAND_COUNT = 1'b1;

  localparam int unsigned ScoreW = 62;
  localparam logic [ScoreW-1:0] SCORE_MAX = {ScoreW{1'b1}};

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         ref_index;
    logic [2:0]         band_index;
    logic [4:0]         coef_index;
    logic signed [15:0] value;
    logic [15:0]        band_weight;
    logic [5:0]         band_components;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [7:0]        best_index;
    logic [ScoreW-1:0] best_score;
    logic              no_match;
  } result_t;

endpackage
`default_nettype wire

// File: src/weighted_band_nearest_reference_top.sv
// A load item (reference, band or probe write) leaves busy low; the next may follow at once.
// A search item (a probe with last set) keeps busy high while each band in use of each
// reference is read and summed (S_READ), weighted (S_WEIGHT) and added (S_ADD), the best score
// being kept in S_REF. S_READ does one store read and one multiply-accumulate step per cycle.
// The result shows for one cycle on done_o as busy falls; the receiver cannot stall.
// Reset clears the band tables, control and datapath registers, not the stores or store reads.
`default_nettype none
module weighted_band_nearest_reference_top
  import wbnr_pkg::*;
#(
  parameter int unsigned MAX_REFERENCES = 256,
  parameter int unsigned MAX_BANDS      = 8,
  parameter int unsigned MAX_COMPONENTS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire item_t               item_i,
  output logic                     done_o,
  output result_t                  result_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned RefW  = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int unsigned BandW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int unsigned CompW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_COMPONENTS + 1);
  localparam int unsigned RCntW = $clog2(MAX_REFERENCES + 1);
  localparam int unsigned BCntW = $clog2(MAX_BANDS + 1);
  localparam int unsigned PAddrW = BandW + CompW;
  localparam int unsigned SAddrW = RefW + PAddrW;
  localparam int unsigned SumW  = 34 + CntW;

  typedef enum logic [2:0] {
    S_IDLE, S_BAND, S_READ, S_ACC, S_WEIGHT, S_ADD, S_REF, S_DONE
  } state_e;

  logic signed [15:0] ref_mem [2**SAddrW];
  logic signed [15:0] probe_mem [2**PAddrW];
  logic [15:0]        weight_q [MAX_BANDS];
  logic [CntW-1:0]    comps_q [MAX_BANDS];
  logic [8:0]         ref_count_q;
  logic [3:0]         band_count_q;

  state_e             state_q;
  logic [RCntW-1:0]   n_q;
  logic [BCntW-1:0]   nb_q;
  logic [RefW-1:0]    ref_q;
  logic [BandW-1:0]   band_q;
  logic [CntW-1:0]    comp_q;
  logic signed [15:0] rd_ref_q, rd_probe_q;
  logic [SumW-1:0]    sum_q;
  logic [SumW+15:0]   wprod_q;
  logic [ScoreW-1:0]  score_q, best_q;
  logic [RefW-1:0]    best_idx_q;
  logic               first_q;
  logic               valid_rd_q;

  wire item_t it = item_i;
  wire logic  accept = start && !busy;
  wire logic  rd_ok = (it.ref_index < MAX_REFERENCES) && (it.band_index < MAX_BANDS)
                      && (it.coef_index < MAX_COMPONENTS);
  wire logic  pr_ok = (it.band_index < MAX_BANDS) && (it.coef_index < MAX_COMPONENTS);

  assign busy = (state_q != S_IDLE);

  logic [RefW-1:0]  wr_ref;
  logic [BandW-1:0] wr_band;
  logic [CompW-1:0] wr_comp;
  assign wr_ref  = RefW'(it.ref_index);
  assign wr_band = BandW'(it.band_index);
  assign wr_comp = CompW'(it.coef_index);

  logic [CntW-1:0] cur_comps;
  assign cur_comps = comps_q[band_q];

  always_ff @(posedge clk_i) begin
    if (accept && mode_e'(it.mode) == MODE_REF && rd_ok) begin
      ref_mem[{wr_ref, wr_band, wr_comp}] <= it.value;
    end
    if (accept && mode_e'(it.mode) == MODE_PROBE && pr_ok) begin
      probe_mem[{wr_band, wr_comp}] <= it.value;
    end
    rd_ref_q   <= ref_mem[{ref_q, band_q, comp_q[CompW-1:0]}];
    rd_probe_q <= probe_mem[{band_q, comp_q[CompW-1:0]}];
  end

  logic signed [16:0] diff;
  logic signed [33:0] diff_w;
  logic [33:0]        sq;
  logic [ScoreW:0]    add_full;
  assign diff = 17'(rd_probe_q) - 17'(rd_ref_q);
  assign diff_w = 34'(diff);
  assign sq   = diff_w * diff_w;
  assign add_full = {1'b0, score_q} + (ScoreW+1)'(wprod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ref_count_q  <= '0;
      band_count_q <= 4'd1;
      done_o       <= 1'b0;
      valid_rd_q   <= 1'b0;
      result_o     <= '0;
      n_q          <= '0;
      nb_q         <= '0;
      ref_q        <= '0;
      band_q       <= '0;
      comp_q       <= '0;
      sum_q        <= '0;
      wprod_q      <= '0;
      score_q      <= '0;
      best_q       <= SCORE_MAX;
      best_idx_q   <= '0;
      first_q      <= 1'b0;
      for (int b = 0; b < MAX_BANDS; b++) begin
        weight_q[b] <= '0;
        comps_q[b]  <= '0;
      end
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REF_COUNT:  ref_count_q  <= cfg_data_i;
          CFG_BAND_COUNT: band_count_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept && mode_e'(it.mode) == MODE_BAND && it.band_index < MAX_BANDS) begin
            weight_q[wr_band] <= it.band_weight;
            comps_q[wr_band]  <= (it.band_components > MAX_COMPONENTS) ?
                                 CntW'(MAX_COMPONENTS) : CntW'(it.band_components);
          end
          if (accept && mode_e'(it.mode) == MODE_PROBE && it.last) begin
            n_q  <= (ref_count_q > MAX_REFERENCES) ? RCntW'(MAX_REFERENCES)
                                                   : RCntW'(ref_count_q);
            nb_q <= (band_count_q > MAX_BANDS) ? BCntW'(MAX_BANDS) : BCntW'(band_count_q);
            ref_q <= '0; band_q <= '0; comp_q <= '0;
            score_q <= '0; sum_q <= '0; first_q <= 1'b1;
            best_q <= SCORE_MAX; best_idx_q <= '0;
            state_q <= S_BAND;
          end
        end
        S_BAND: begin
          if (n_q == '0) begin
            state_q <= S_DONE;
          end else if (BCntW'(band_q) >= nb_q || nb_q == '0) begin
            state_q <= S_REF;
          end else begin
            sum_q <= '0; comp_q <= '0; valid_rd_q <= 1'b0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          // address issued; data registered next cycle
          if (valid_rd_q) sum_q <= sum_q + SumW'(sq);
          if (comp_q >= cur_comps) begin
            valid_rd_q <= 1'b0;
            state_q <= S_WEIGHT;
          end else begin
            valid_rd_q <= 1'b1;
            comp_q <= comp_q + 1'b1;
          end
        end
        S_WEIGHT: begin
          wprod_q <= (SumW+16)'(sum_q) * (SumW+16)'(weight_q[band_q]);
          state_q <= S_ADD;
        end
        S_ADD: begin
          score_q <= add_full[ScoreW] ? SCORE_MAX : add_full[ScoreW-1:0];
          band_q  <= band_q + 1'b1;
          if (BCntW'(band_q) + 1'b1 >= nb_q) state_q <= S_REF;
          else state_q <= S_BAND;
        end
        S_REF: begin
          if (first_q || score_q < best_q) begin
            best_q <= score_q; best_idx_q <= ref_q;
          end
          first_q <= 1'b0;
          score_q <= '0; band_q <= '0;
          if (RCntW'(ref_q) + 1'b1 >= n_q) state_q <= S_DONE;
          else begin
            ref_q <= ref_q + 1'b1;
            state_q <= S_BAND;
          end
        end
        S_DONE: begin
          done_o <= 1'b1;
          result_o.no_match   <= (n_q == '0);
          result_o.best_index <= (n_q == '0) ? 8'd0 : 8'(best_idx_q);
          result_o.best_score <= (n_q == '0) ? '0 : best_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  property p_done_from_search;
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(state_q == S_DONE);
  endproperty
  a_done: assert property (p_done_from_search) else $error("result without search");

  property p_idle_after_done;
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy;
  endproperty
  a_idle: assert property (p_idle_after_done) else $error("busy after result");

  property p_nomatch_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (done_o && result_o.no_match) |-> (result_o.best_score == '0);
  endproperty
  a_nm: assert property (p_nomatch_zero) else $error("no-match with score");

endmodule
`default_nettype wire

// File: test/tb.sv
`default_nettype none
module tb;
  import wbnr_pkg::*;

  localparam int unsigned NRefs  = 256;
  localparam int unsigned NBands = 8;
  localparam int unsigned NComps = 32;
  localparam int unsigned IdleLimit = 500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  item_t item_q = '0;
  logic done_o;
  result_t result_o;
  logic cfg_we_q = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_q = '0;
  logic [CfgDataW-1:0] cfg_data_q = '0;

  weighted_band_nearest_reference_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_q),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_q), .cfg_idx_i(cfg_idx_q),
    .cfg_data_i(cfg_data_q)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block
  shortint ref_mem [NRefs][NBands][NComps];
  bit ref_wr [NRefs][NBands][NComps];
  shortint probe_mem [NBands][NComps];
  bit probe_wr [NBands][NComps];
  logic [15:0] weight_tab [NBands];
  int unsigned comp_tab [NBands];
  int unsigned ref_count_reg = 0;
  int unsigned band_count_reg = 1;

  result_t best_match_q [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic longint unsigned score_of(int unsigned r, int unsigned bands);
    longint unsigned total;
    longint unsigned sq;
    longint d;
    total = 0;
    for (int b = 0; b < bands; b++) begin
      sq = 0;
      for (int c = 0; c < comp_tab[b]; c++) begin
        d = longint'(probe_mem[b][c]) - longint'(ref_mem[r][b][c]);
        sq += longint'(d * d);
      end
      total += sq * weight_tab[b];
      if (total > longint'(SCORE_MAX)) total = SCORE_MAX;
    end
    return total;
  endfunction

  function automatic result_t nearest_ref();
    result_t res;
    int unsigned n;
    int unsigned bands;
    longint unsigned s;
    longint unsigned best;
    n = (ref_count_reg < NRefs) ? ref_count_reg : NRefs;
    bands = (band_count_reg < NBands) ? band_count_reg : NBands;
    res = '0;
    if (n == 0) begin
      res.no_match = 1'b1;
      return res;
    end
    best = SCORE_MAX;
    for (int unsigned i = 0; i < n; i++) begin
      s = score_of(i, bands);
      if (i == 0 || s < best) begin
        best = s;
        res.best_index = i[7:0];
      end
    end
    res.best_score = best[ScoreW-1:0];
    return res;
  endfunction

  function automatic void apply_item(item_t it);
    case (it.mode)
      MODE_REF: begin
        ref_mem[it.ref_index][it.band_index][it.coef_index] = it.value;
        ref_wr[it.ref_index][it.band_index][it.coef_index] = 1'b1;
      end
      MODE_BAND: begin
        weight_tab[it.band_index] = it.band_weight;
        comp_tab[it.band_index] = (it.band_components > NComps) ? NComps : it.band_components;
      end
      MODE_PROBE: begin
        probe_mem[it.band_index][it.coef_index] = it.value;
        probe_wr[it.band_index][it.coef_index] = 1'b1;
        if (it.last) best_match_q.push_back(nearest_ref());
      end
      default: ;
    endcase
  endfunction

  function automatic item_t make_item(logic [1:0] mode, logic last);
    item_t it;
    it.mode = mode;
    it.ref_index = 8'($urandom_range(0, 255));
    it.band_index = 3'($urandom_range(0, 7));
    it.coef_index = 5'($urandom_range(0, 31));
    it.value = 16'($urandom_range(0, 65535));
    it.band_weight = 16'($urandom_range(0, 65535));
    it.band_components = 6'($urandom_range(0, 63));
    it.last = last;
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(item_t it);
    int unsigned gap;
    item_q <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    apply_item(it);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (best_match_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, int unsigned data);
    drain();
    cfg_we_q <= 1'b1;
    cfg_idx_q <= idx;
    cfg_data_q <= data[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
    if (idx == CFG_REF_COUNT) ref_count_reg = data & 9'h1ff;
    else band_count_reg = data & 4'hf;
  endtask

  task automatic band_setup(int unsigned b, int unsigned w, int unsigned nc);
    item_t it;
    it = make_item(MODE_BAND, 1'b0);
    it.band_index = 3'(b);
    it.band_weight = 16'(w);
    it.band_components = 6'(nc);
    send_item(it);
  endtask

  // write every entry the coming search reads that has not been written yet, then send a last probe to start it
  task automatic fill_and_search();
    item_t it;
    int unsigned n;
    int unsigned bands;
    n = (ref_count_reg < NRefs) ? ref_count_reg : NRefs;
    bands = (band_count_reg < NBands) ? band_count_reg : NBands;
    for (int b = 0; b < bands; b++) begin
      for (int c = 0; c < comp_tab[b]; c++) begin
        for (int r = 0; r < n; r++) begin
          if (!ref_wr[r][b][c]) begin
            it = make_item(MODE_REF, 1'($urandom_range(0, 1)));
            it.ref_index = 8'(r);
            it.band_index = 3'(b);
            it.coef_index = 5'(c);
            send_item(it);
          end
        end
        if (!probe_wr[b][c]) begin
          it = make_item(MODE_PROBE, 1'b0);
          it.band_index = 3'(b);
          it.coef_index = 5'(c);
          send_item(it);
        end
      end
    end
    send_item(make_item(MODE_PROBE, 1'b1));
  endtask

  task automatic test_no_references();
    send_item(make_item(MODE_PROBE, 1'b1));
    send_item(make_item(MODE_NONE, 1'b1));
    send_item(make_item(MODE_PROBE, 1'b1));
    drain();
  endtask

  task automatic test_field_extremes();
    item_t it;
    write_cfg(CFG_REF_COUNT, 2);
    write_cfg(CFG_BAND_COUNT, 2);
    band_setup(0, 16'hffff, 63);
    band_setup(1, 0, 0);
    band_setup(7, 16'hffff, 32);
    for (int c = 0; c < NComps; c++) begin
      it = make_item(MODE_REF, 1'b1);
      it.ref_index = 0; it.band_index = 0; it.coef_index = 5'(c); it.value = 16'sh7fff;
      send_item(it);
      it.ref_index = 1; it.value = 16'sh8000;
      send_item(it);
      it = make_item(MODE_PROBE, 1'b0);
      it.band_index = 0; it.coef_index = 5'(c); it.value = 16'sh8000;
      send_item(it);
    end
    it = make_item(MODE_REF, 1'b0);
    it.ref_index = 255; it.band_index = 7; it.coef_index = 31;
    send_item(it);
    fill_and_search();
    drain();
  endtask

  task automatic test_zero_bands_and_ties();
    item_t it;
    write_cfg(CFG_BAND_COUNT, 0);
    write_cfg(CFG_REF_COUNT, 3);
    fill_and_search();
    write_cfg(CFG_BAND_COUNT, 1);
    band_setup(0, 16'h0100, 1);
    for (int r = 0; r < 3; r++) begin
      it = make_item(MODE_REF, 1'b0);
      it.ref_index = 8'(r); it.band_index = 0; it.coef_index = 0; it.value = 16'sd5;
      send_item(it);
    end
    it = make_item(MODE_PROBE, 1'b1);
    it.band_index = 0; it.coef_index = 0; it.value = 16'sd9;
    send_item(it);
    drain();
  endtask

  task automatic test_largest_sizes();
    write_cfg(CFG_BAND_COUNT, 15);
    for (int b = 0; b < NBands; b++) begin
      band_setup(b, $urandom_range(0, 65535), (b == 0) ? 1 : 0);
    end
    write_cfg(CFG_REF_COUNT, 511);
    fill_and_search();
    write_cfg(CFG_REF_COUNT, 256);
    fill_and_search();
    write_cfg(CFG_BAND_COUNT, 8);
    band_setup(3, 16'hffff, 32);
    write_cfg(CFG_REF_COUNT, 2);
    fill_and_search();
    drain();
  endtask

  task automatic test_random_searches();
    int unsigned k;
    int unsigned r;
    item_t it;
    while (items_sent < 1500) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) write_cfg(CFG_REF_COUNT, $urandom_range(0, 6));
      if ($urandom_range(0, 2) == 0) write_cfg(CFG_BAND_COUNT, $urandom_range(0, 15));
      k = $urandom_range(2, 30);
      repeat (k) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          it = make_item(MODE_BAND, 1'($urandom_range(0, 1)));
          it.band_components = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                             : 6'($urandom_range(0, 6));
        end else if (r < 55) begin
          it = make_item(MODE_REF, 1'($urandom_range(0, 1)));
          it.ref_index = 8'($urandom_range(0, 7));
        end else if (r < 90) begin
          it = make_item(MODE_PROBE, 1'b0);
        end else begin
          it = make_item(MODE_NONE, 1'($urandom_range(0, 1)));
        end
        send_item(it);
      end
      fill_and_search();
    end
    no_gaps = 1'b0;
    drain();
  endtask

  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni) begin
      if ((start && !busy) || done_o || cfg_we_q) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL weighted_band_nearest_reference_top");
        $finish;
      end
      if (done_o) begin
        if (best_match_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result_o);
        end else begin
          exp_res = best_match_q.pop_front();
          if (result_o.best_index !== exp_res.best_index ||
              result_o.best_score !== exp_res.best_score ||
              result_o.no_match !== exp_res.no_match) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected idx %0d score %0d nm %0d, got idx %0d score %0d nm %0d",
                       exp_res.best_index, exp_res.best_score, exp_res.no_match,
                       result_o.best_index, result_o.best_score, result_o.no_match);
          end
        end
      end
    end
  end

  initial begin
    for (int b = 0; b < NBands; b++) begin
      weight_tab[b] = '0;
      comp_tab[b] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_references();
    test_field_extremes();
    test_zero_bands_and_ties();
    test_largest_sizes();
    test_random_searches();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && best_match_q.size() == 0) begin
      $display("PASS weighted_band_nearest_reference_top");
    end else begin
      $display("FAIL weighted_band_nearest_reference_top");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/wbnr_pkg.sv
src/weighted_band_nearest_reference_top.sv
test/tb.sv
